// ----- sv/pib_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pib_pkg: shared types and constants for the palette icon blitter
// Opcodes, register indexes, configuration and inter-block structs, and the
// color formatting helper.
// ----------------------------------------------------------------------------
package pib_pkg;

    localparam int PIX_PER_CHUNK = 8;
    localparam int IDX_W         = 4;
    localparam int COLOR_W       = 24;
    localparam int COORD_W       = 11;
    localparam int SLOT_W        = 4;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 11;
    localparam int QUEUE_DEPTH   = 2;

    typedef enum logic
    {
        OP_LOAD  = 1'b0,
        OP_CHUNK = 1'b1
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        REG_FOUR_BIT_MODE = 3'd0,
        REG_ICON_WIDTH    = 3'd1,
        REG_ICON_HEIGHT   = 3'd2,
        REG_DEST_X        = 3'd3,
        REG_DEST_Y        = 3'd4,
        REG_CLIP_WIDTH    = 3'd5,
        REG_CLIP_HEIGHT   = 3'd6,
        REG_WIDE_COLOR    = 3'd7
    } cfg_reg_t;

    typedef struct packed
    {
        logic        four_bit_mode;
        logic [7:0]  icon_width;
        logic [7:0]  icon_height;
        logic [9:0]  dest_x;
        logic [9:0]  dest_y;
        logic [10:0] clip_width;
        logic [10:0] clip_height;
        logic        wide_color;
    } cfg_t;

    // palette write from front to back
    typedef struct packed
    {
        logic               we;
        logic [SLOT_W-1:0]  slot;
        logic [COLOR_W-1:0] color;
    } pal_wr_t;

    // one classified chunk; bit p of emit and nibble p of idx belong to pixel p
    typedef struct packed
    {
        logic [PIX_PER_CHUNK-1:0]       emit;
        logic [PIX_PER_CHUNK*IDX_W-1:0] idx;
        logic [COORD_W-1:0]             base_x;
        logic [COORD_W-1:0]             y;
    } chunk_t;

    // status the front needs from queue and back
    typedef struct packed
    {
        logic q_full;
        logic q_empty;
        logic back_busy;
    } fe_status_t;

    function automatic logic [COLOR_W-1:0] format_color(
        input logic [COLOR_W-1:0] c,
        input logic               wide
    );
        logic [COLOR_W-1:0] res;
        if (wide)
        begin
            res = c;
        end
        else
        begin
            res = {8'd0, c[23:19], c[15:10], c[7:3]};
        end
        return res;
    endfunction

endpackage

// ----- sv/pib_cmd_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pib_cmd_if: input word channel
// Palette loads and eight-pixel chunks, valid/ready handshake.
// ----------------------------------------------------------------------------
interface pib_cmd_if;
    logic              valid;
    logic              ready;
    pib_pkg::opcode_t  opcode;
    logic [3:0]        palette_slot;
    logic [23:0]       palette_color;
    logic [31:0]       image_bits;
    logic [7:0]        mask_bits;

    modport source
    (
        output valid, opcode, palette_slot, palette_color, image_bits, mask_bits,
        input  ready
    );
    modport sink
    (
        input  valid, opcode, palette_slot, palette_color, image_bits, mask_bits,
        output ready
    );
endinterface

// ----- sv/pib_pix_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pib_pix_if: pixel write channel
// One framebuffer pixel write per word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface pib_pix_if;
    logic        valid;
    logic        ready;
    logic [10:0] screen_x;
    logic [10:0] screen_y;
    logic [23:0] pixel_color;
    logic        last;

    modport source
    (
        output valid, screen_x, screen_y, pixel_color, last,
        input  ready
    );
    modport sink
    (
        input  valid, screen_x, screen_y, pixel_color, last,
        output ready
    );
endinterface

// ----- sv/pib_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pib_front: command intake and chunk classification
// Tracks row/chunk position, decides which pixels of a chunk are drawn and
// forwards palette loads once the back end has drained.
// ----------------------------------------------------------------------------
module pib_front
(
    input  logic                clk,
    input  logic                rst_n,
    pib_cmd_if.sink             cmd,
    input  pib_pkg::cfg_t       cfg,
    input  pib_pkg::fe_status_t stat,
    output pib_pkg::pal_wr_t    pal_wr,
    output logic                push,
    output pib_pkg::chunk_t     push_entry
);
    import pib_pkg::*;

    logic [7:0]               row_reg;
    logic [7:0]               row_next;
    logic [4:0]               chunk_reg;
    logic [4:0]               chunk_next;
    logic [5:0]               cpr;
    logic [5:0]               cpr_raw;
    logic                     restart;
    logic [7:0]               row_cur;
    logic [4:0]               chunk_cur;
    logic                     row_drawn;
    logic                     accept;
    logic                     is_chunk;
    logic [PIX_PER_CHUNK-1:0] emit;
    logic [PIX_PER_CHUNK*IDX_W-1:0] idx;
    logic [5:0]               chunk_inc;
    logic [8:0]               row_inc;

    // chunks per row, at least one
    assign cpr_raw = 6'((9'(cfg.icon_width) + 9'd7) >> 3);
    assign cpr     = (cpr_raw == 6'd0) ? 6'd1 : cpr_raw;

    // counters left out of range by a register change restart the icon
    assign restart   = (row_reg >= cfg.icon_height) || (6'(chunk_reg) >= cpr);
    assign row_cur   = restart ? 8'd0 : row_reg;
    assign chunk_cur = restart ? 5'd0 : chunk_reg;

    // only the top clip_height rows are drawn
    assign row_drawn = (row_cur < cfg.icon_height) &&
                       ((12'(row_cur) + 12'(cfg.clip_height)) >= 12'(cfg.icon_height));

    // per-pixel index extraction and draw decision
    always_comb
    begin
        logic [7:0]       j;
        logic [IDX_W-1:0] nib;
        logic             mbit;
        emit = '0;
        idx  = '0;
        for (int p = 0; p < PIX_PER_CHUNK; p++)
        begin
            j    = {chunk_cur, 3'(p)};
            nib  = cfg.four_bit_mode ? cmd.image_bits[31-4*p -: 4]
                                     : {3'd0, cmd.image_bits[7-p]};
            mbit = cmd.mask_bits[7-p];
            idx[IDX_W*p +: IDX_W] = nib;
            emit[p] = row_drawn && (j < cfg.icon_width) &&
                      (11'(j) < cfg.clip_width) &&
                      !((nib == '0) && mbit);
        end
    end

    assign push_entry.emit   = emit;
    assign push_entry.idx    = idx;
    assign push_entry.base_x = 11'(cfg.dest_x) + 11'({chunk_cur, 3'd0});
    assign push_entry.y      = 11'(cfg.dest_y) + 11'(cfg.icon_height) - 11'd1
                               - 11'(row_cur);

    // loads wait until every earlier chunk has read the palette
    assign is_chunk  = (cmd.opcode == OP_CHUNK);
    assign cmd.ready = is_chunk ? !stat.q_full : (stat.q_empty && !stat.back_busy);
    assign accept    = cmd.valid && cmd.ready;
    assign push      = accept && is_chunk && (emit != '0);

    assign pal_wr.we    = accept && !is_chunk;
    assign pal_wr.slot  = cmd.palette_slot;
    assign pal_wr.color = cmd.palette_color;

    // position advance
    assign chunk_inc = 6'(chunk_cur) + 6'd1;
    assign row_inc   = 9'(row_cur) + 9'd1;

    always_comb
    begin
        row_next   = row_reg;
        chunk_next = chunk_reg;
        if (accept && is_chunk)
        begin
            if (chunk_inc >= cpr)
            begin
                chunk_next = 5'd0;
                row_next   = (row_inc >= 9'(cfg.icon_height)) ? 8'd0 : row_inc[7:0];
            end
            else
            begin
                chunk_next = chunk_inc[4:0];
                row_next   = row_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg   <= 8'd0;
            chunk_reg <= 5'd0;
        end
        else
        begin
            row_reg   <= row_next;
            chunk_reg <= chunk_next;
        end
    end

endmodule

// ----- sv/pib_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pib_queue: chunk queue between front and back
// Small FIFO of classified chunks so either side can stall on its own.
// ----------------------------------------------------------------------------
module pib_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  pib_pkg::chunk_t push_data,
    input  logic            pop,
    output pib_pkg::chunk_t pop_data,
    output logic            not_empty,
    output logic            full,
    output logic            empty
);
    import pib_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    chunk_t             slots_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push;
    logic               do_pop;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign not_empty = !empty;
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign pop_data  = slots_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

// ----- sv/pib_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pib_back: pixel emitter
// Holds the palette, walks the drawn pixels of one chunk at a time and
// writes one formatted pixel word per cycle into the output register while pix is not stalled.
// ----------------------------------------------------------------------------
module pib_back
#(
    parameter int PALETTE_ENTRIES = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wide_color,
    input  pib_pkg::pal_wr_t pal_wr,
    input  logic             q_valid,
    input  pib_pkg::chunk_t  q_data,
    output logic             q_pop,
    output logic             busy,
    pib_pix_if.source        pix
);
    import pib_pkg::*;

    localparam int PAL_AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

    logic [COLOR_W-1:0]             palette_reg [PALETTE_ENTRIES];
    logic                           cur_valid_reg;
    logic [PIX_PER_CHUNK-1:0]       cur_mask_reg;
    logic [PIX_PER_CHUNK*IDX_W-1:0] cur_idx_reg;
    logic [COORD_W-1:0]             cur_x_reg;
    logic [COORD_W-1:0]             cur_y_reg;
    logic                           out_valid_reg;
    logic [COORD_W-1:0]             out_x_reg;
    logic [COORD_W-1:0]             out_y_reg;
    logic [COLOR_W-1:0]             out_color_reg;
    logic                           out_last_reg;

    logic [2:0]                     sel;
    logic [PIX_PER_CHUNK-1:0]       sel_onehot;
    logic [PIX_PER_CHUNK-1:0]       mask_rest;
    logic [IDX_W-1:0]               sel_idx;
    logic [COLOR_W-1:0]             raw_color;
    logic                           adv;
    logic                           done;

    // palette, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PALETTE_ENTRIES; i++)
            begin
                palette_reg[i] <= '0;
            end
        end
        else if (pal_wr.we && (32'(pal_wr.slot) < PALETTE_ENTRIES))
        begin
            palette_reg[pal_wr.slot[PAL_AW-1:0]] <= pal_wr.color;
        end
    end

    // lowest pending pixel goes next
    always_comb
    begin
        sel        = 3'd0;
        sel_onehot = '0;
        for (int p = PIX_PER_CHUNK - 1; p >= 0; p--)
        begin
            if (cur_mask_reg[p])
            begin
                sel        = 3'(p);
                sel_onehot = PIX_PER_CHUNK'(1) << p;
            end
        end
    end

    assign mask_rest = cur_mask_reg & ~sel_onehot;
    assign sel_idx   = cur_idx_reg[{sel, 2'b00} +: IDX_W];
    assign raw_color = (32'(sel_idx) < PALETTE_ENTRIES) ? palette_reg[sel_idx[PAL_AW-1:0]]
                                                        : '0;

    assign adv   = cur_valid_reg && (!out_valid_reg || pix.ready);
    assign done  = adv && (mask_rest == '0);
    assign q_pop = q_valid && (!cur_valid_reg || done);
    assign busy  = cur_valid_reg;

    // current chunk control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
        end
        else if (q_pop)
        begin
            cur_valid_reg <= 1'b1;
        end
        else if (done)
        begin
            cur_valid_reg <= 1'b0;
        end
    end

    // current chunk payload
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_mask_reg <= q_data.emit;
            cur_idx_reg  <= q_data.idx;
            cur_x_reg    <= q_data.base_x;
            cur_y_reg    <= q_data.y;
        end
        else if (adv)
        begin
            cur_mask_reg <= mask_rest;
        end
    end

    // output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pix.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_x_reg     <= cur_x_reg + 11'(sel);
            out_y_reg     <= cur_y_reg;
            out_color_reg <= format_color(raw_color, wide_color);
            out_last_reg  <= (mask_rest == '0);
        end
    end

    assign pix.valid       = out_valid_reg;
    assign pix.screen_x    = out_x_reg;
    assign pix.screen_y    = out_y_reg;
    assign pix.pixel_color = out_color_reg;
    assign pix.last        = out_last_reg;

endmodule

// ----- sv/palette_icon_blitter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_icon_blitter: palettized icon to framebuffer pixel writes
// Expands 1 bpp / 4 bpp icon chunks through a color palette, with mask
// transparency, clipping and RGB565 / RGB888 output.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake       | word
//  ---------+-----+-----------------+-----------------------------------------
//  cmd      | in  | valid/ready     | opcode, palette_slot, palette_color,
//           |     |                 | image_bits, mask_bits
//  pix      | out | valid/ready     | screen_x, screen_y, pixel_color, last
//  cfg      | in  | cfg_we          | cfg_index, cfg_data
//
// A chunk is accepted whenever the two-entry chunk queue has room; the back
// end then emits one pixel word per cycle while pix is not stalled, so a chunk
// yields as many words as it has drawn pixels (0 to 8) at the pixel port.
// A palette load waits until the queue is empty and the back end is idle.
// Reset clears the palette, row/chunk position and registers; no sweep.
// A stall on pix holds the output register and fills the queue behind it.
// ----------------------------------------------------------------------------
module palette_icon_blitter
#(
    parameter int PALETTE_ENTRIES = 16
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [pib_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pib_pkg::CFG_DATA_W-1:0]  cfg_data,
    pib_cmd_if.sink                         cmd,
    pib_pix_if.source                       pix
);
    import pib_pkg::*;

    cfg_t       cfg_reg;
    fe_status_t stat;
    pal_wr_t    pal_wr;
    logic       push;
    chunk_t     push_entry;
    logic       q_pop;
    chunk_t     q_data;
    logic       q_valid;
    logic       q_full;
    logic       q_empty;
    logic       back_busy;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.four_bit_mode <= 1'b0;
            cfg_reg.icon_width    <= 8'd32;
            cfg_reg.icon_height   <= 8'd32;
            cfg_reg.dest_x        <= 10'd0;
            cfg_reg.dest_y        <= 10'd0;
            cfg_reg.clip_width    <= 11'd1024;
            cfg_reg.clip_height   <= 11'd1024;
            cfg_reg.wide_color    <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_FOUR_BIT_MODE: cfg_reg.four_bit_mode <= cfg_data[0];
                REG_ICON_WIDTH:    cfg_reg.icon_width    <= cfg_data[7:0];
                REG_ICON_HEIGHT:   cfg_reg.icon_height   <= cfg_data[7:0];
                REG_DEST_X:        cfg_reg.dest_x        <= cfg_data[9:0];
                REG_DEST_Y:        cfg_reg.dest_y        <= cfg_data[9:0];
                REG_CLIP_WIDTH:    cfg_reg.clip_width    <= cfg_data;
                REG_CLIP_HEIGHT:   cfg_reg.clip_height   <= cfg_data;
                REG_WIDE_COLOR:    cfg_reg.wide_color    <= cfg_data[0];
            endcase
        end
    end

    assign stat.q_full    = q_full;
    assign stat.q_empty   = q_empty;
    assign stat.back_busy = back_busy;

    pib_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .cfg        (cfg_reg),
        .stat       (stat),
        .pal_wr     (pal_wr),
        .push       (push),
        .push_entry (push_entry)
    );

    pib_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_entry),
        .pop       (q_pop),
        .pop_data  (q_data),
        .not_empty (q_valid),
        .full      (q_full),
        .empty     (q_empty)
    );

    pib_back #(.PALETTE_ENTRIES(PALETTE_ENTRIES)) u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .wide_color (cfg_reg.wide_color),
        .pal_wr     (pal_wr),
        .q_valid    (q_valid),
        .q_data     (q_data),
        .q_pop      (q_pop),
        .busy       (back_busy),
        .pix        (pix)
    );

    // a palette write never overtakes a chunk still waiting for its colors
    a_load_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        pal_wr.we |-> (q_empty && !back_busy))
        else $error("palette written while chunks pending");

    // the front never pushes into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("chunk queue overflow");

    // the back end only goes idle once the last word of a chunk is in the output register
    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(back_busy) |-> (pix.valid && pix.last))
        else $error("back end went idle without a last word");

endmodule
